@@ src/integer_upscale_pixel_writer_unit_assert.svh @@
// Assertion macros shared by the queue and back-end RTL modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INTEGER_UPSCALE_PIXEL_WRITER_UNIT_ASSERT_SVH
`define INTEGER_UPSCALE_PIXEL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IUPW_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iupw assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define IUPW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iupw assertion failed (next cycle)");

`endif

@@ src/iupw_pkg.sv @@
package iupw_pkg;

    localparam int MAX_SCALE    = 8;
    localparam int COORD_BITS   = 12;
    localparam int ADDRESS_BITS = 24;

    localparam int CHAN_W      = 8;
    localparam int DIM_W       = 13;
    localparam int LINE_W      = 16;
    localparam int PAN_W       = 24;
    localparam int PAN_FIELD_W = 12;
    localparam int PIX_BYTES_W = 3;
    localparam int LAYOUT_W    = 40;
    localparam int GROUP_W     = 10;
    localparam int WORD_W      = 32;
    localparam int ADDR_OUT_W  = 24;

    localparam int REG_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int PROD_W  = DIM_W + SCALE_W;
    localparam int OFF_W   = DIM_W - 1;
    localparam int CSC_W   = COORD_BITS + SCALE_W;
    localparam int BASE_W  = ((CSC_W > OFF_W) ? CSC_W : OFF_W) + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [8:0] ROUND_HALF = 9'd127;
    localparam logic [8:0] CHAN_FULL  = 9'd255;

    typedef enum logic [2:0] {
        REG_PHYS_WIDTH,
        REG_PHYS_HEIGHT,
        REG_CANVAS_WIDTH,
        REG_CANVAS_HEIGHT,
        REG_LINE_BYTES,
        REG_PAN_OFFSETS,
        REG_PIXEL_BYTES,
        REG_CHANNEL_LAYOUT
    } reg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0]       phys_width;
        logic [DIM_W-1:0]       phys_height;
        logic [DIM_W-1:0]       canvas_width;
        logic [DIM_W-1:0]       canvas_height;
        logic [LINE_W-1:0]      line_bytes;
        logic [PAN_W-1:0]       pan_offsets;
        logic [PIX_BYTES_W-1:0] pixel_bytes;
        logic [LAYOUT_W-1:0]    channel_layout;
    } cfg_t;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] start_addr;
        logic [WORD_W-1:0]       word;
        logic [SCALE_W-1:0]      scale;
        logic [PIX_BYTES_W-1:0]  bpp;
        logic                    too_small;
    } work_t;

    // Computes (v * (2^len - 1) + 127) / 255 without a divider, using
    // 2^8 = 1 modulo 255, then shifts the result to the field offset.
    function automatic logic [WORD_W-1:0] rescale_channel(
        input logic [CHAN_W-1:0]  v,
        input logic [GROUP_W-1:0] group
    );
        logic [4:0]        off;
        logic [4:0]        len;
        logic [14:0]       w;
        logic [8:0]        fold;
        logic              fold_ge;
        logic [7:0]        rem;
        logic [7:0]        quo_low;
        logic [WORD_W-1:0] rep;
        logic [WORD_W-1:0] q;
        logic [8:0]        t;
        off     = group[4:0];
        len     = group[9:5];
        w       = 15'(v) << len[2:0];
        fold    = 9'(w[14:8]) + 9'(w[7:0]);
        fold_ge = (fold >= CHAN_FULL);
        rem     = fold_ge ? 8'(fold - CHAN_FULL) : fold[7:0];
        quo_low = 8'(w[14:8]) + 8'(fold_ge);
        case (len[4:3])
            2'd0:    rep = '0;
            2'd1:    rep = WORD_W'(w);
            2'd2:    rep = WORD_W'(w) + (WORD_W'(w) << 8);
            default: rep = WORD_W'(w) + (WORD_W'(w) << 8) + (WORD_W'(w) << 16);
        endcase
        q = rep + WORD_W'(quo_low);
        t = 9'(rem) + ROUND_HALF;
        if (t < 9'(v))
        begin
            q = q - WORD_W'(1);
        end
        else if ((t - 9'(v)) >= CHAN_FULL)
        begin
            q = q + WORD_W'(1);
        end
        return q << off;
    endfunction

    function automatic logic [PIX_BYTES_W-1:0] clamp_bpp(input logic [PIX_BYTES_W-1:0] pb);
        logic [PIX_BYTES_W-1:0] r;
        if (pb < PIX_BYTES_W'(2))
        begin
            r = PIX_BYTES_W'(2);
        end
        else if (pb > PIX_BYTES_W'(4))
        begin
            r = PIX_BYTES_W'(4);
        end
        else
        begin
            r = pb;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mask_word(
        input logic [WORD_W-1:0]      word,
        input logic [PIX_BYTES_W-1:0] bpp
    );
        logic [WORD_W-1:0] r;
        case (bpp)
            PIX_BYTES_W'(2): r = word & WORD_W'(32'h0000_FFFF);
            PIX_BYTES_W'(3): r = word & WORD_W'(32'h00FF_FFFF);
            default:         r = word;
        endcase
        return r;
    endfunction

endpackage

@@ src/iupw_regs.sv @@
module iupw_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [iupw_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [iupw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iupw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output iupw_pkg::cfg_t                     cfg
);
    import iupw_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[REG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phys_width     <= DIM_W'(320);
            cfg_reg.phys_height    <= DIM_W'(240);
            cfg_reg.canvas_width   <= DIM_W'(320);
            cfg_reg.canvas_height  <= DIM_W'(240);
            cfg_reg.line_bytes     <= LINE_W'(640);
            cfg_reg.pan_offsets    <= '0;
            cfg_reg.pixel_bytes    <= PIX_BYTES_W'(2);
            cfg_reg.channel_layout <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_PHYS_WIDTH:     cfg_reg.phys_width     <= pwdata[DIM_W-1:0];
                REG_PHYS_HEIGHT:    cfg_reg.phys_height    <= pwdata[DIM_W-1:0];
                REG_CANVAS_WIDTH:   cfg_reg.canvas_width   <= pwdata[DIM_W-1:0];
                REG_CANVAS_HEIGHT:  cfg_reg.canvas_height  <= pwdata[DIM_W-1:0];
                REG_LINE_BYTES:     cfg_reg.line_bytes     <= pwdata[LINE_W-1:0];
                REG_PAN_OFFSETS:    cfg_reg.pan_offsets    <= pwdata[PAN_W-1:0];
                REG_PIXEL_BYTES:    cfg_reg.pixel_bytes    <= pwdata[PIX_BYTES_W-1:0];
                REG_CHANNEL_LAYOUT: cfg_reg.channel_layout <= pwdata[LAYOUT_W-1:0];
                default:            cfg_reg.pixel_bytes    <= cfg_reg.pixel_bytes;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PHYS_WIDTH:     prdata = APB_DATA_W'(cfg_reg.phys_width);
            REG_PHYS_HEIGHT:    prdata = APB_DATA_W'(cfg_reg.phys_height);
            REG_CANVAS_WIDTH:   prdata = APB_DATA_W'(cfg_reg.canvas_width);
            REG_CANVAS_HEIGHT:  prdata = APB_DATA_W'(cfg_reg.canvas_height);
            REG_LINE_BYTES:     prdata = APB_DATA_W'(cfg_reg.line_bytes);
            REG_PAN_OFFSETS:    prdata = APB_DATA_W'(cfg_reg.pan_offsets);
            REG_PIXEL_BYTES:    prdata = APB_DATA_W'(cfg_reg.pixel_bytes);
            REG_CHANNEL_LAYOUT: prdata = APB_DATA_W'(cfg_reg.channel_layout);
            default:            prdata = '0;
        endcase
    end

endmodule

@@ src/iupw_front.sv @@
module iupw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [iupw_pkg::CHAN_W-1:0]   red,
    input  logic [iupw_pkg::CHAN_W-1:0]   green,
    input  logic [iupw_pkg::CHAN_W-1:0]   blue,
    input  logic [iupw_pkg::CHAN_W-1:0]   alpha,
    input  iupw_pkg::cfg_t                cfg,
    input  logic                          full,
    output logic                          push,
    output iupw_pkg::work_t               push_data
);
    import iupw_pkg::*;

    localparam int CMP_W = ((COORD_BITS + 1) > DIM_W) ? (COORD_BITS + 1) : DIM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OFFSET,
        ST_BASE,
        ST_PUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [COORD_BITS-1:0]   canvas_col_reg, canvas_col_next;
    logic [COORD_BITS-1:0]   canvas_row_reg, canvas_row_next;
    logic [CHAN_W-1:0]       red_reg, red_next;
    logic [CHAN_W-1:0]       green_reg, green_next;
    logic [CHAN_W-1:0]       blue_reg, blue_next;
    logic [CHAN_W-1:0]       alpha_reg, alpha_next;
    logic [COORD_BITS-1:0]   col_snap_reg, col_snap_next;
    logic [COORD_BITS-1:0]   row_snap_reg, row_snap_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;
    logic [WORD_W-1:0]       word_reg, word_next;
    logic [OFF_W-1:0]        offx_reg, offx_next;
    logic [OFF_W-1:0]        offy_reg, offy_next;
    logic [CSC_W-1:0]        colsc_reg, colsc_next;
    logic [CSC_W-1:0]        rowsc_reg, rowsc_next;
    logic [BASE_W-1:0]       basex_reg, basex_next;
    logic [BASE_W-1:0]       basey_reg, basey_next;

    logic                    accept;
    logic [COORD_BITS:0]     col_inc;
    logic [COORD_BITS:0]     row_inc;
    logic [SCALE_W-1:0]      scale_calc;
    logic [WORD_W-1:0]       word_calc;
    logic [PIX_BYTES_W-1:0]  bpp;
    logic [PROD_W-1:0]       prod_w;
    logic [PROD_W-1:0]       prod_h;
    logic [ADDRESS_BITS-1:0] row_part;
    logic [ADDRESS_BITS-1:0] col_part;

    assign bpp = clamp_bpp(cfg.pixel_bytes);

    always_comb
    begin
        scale_calc = '0;
        for (int s = 1; s <= MAX_SCALE; s++)
        begin
            if ((PROD_W'(cfg.canvas_width) * PROD_W'(s) <= PROD_W'(cfg.phys_width)) &&
                (PROD_W'(cfg.canvas_height) * PROD_W'(s) <= PROD_W'(cfg.phys_height)))
            begin
                scale_calc = scale_calc + SCALE_W'(1);
            end
        end
        if (cfg.canvas_width == '0 || cfg.canvas_height == '0)
        begin
            scale_calc = '0;
        end
    end

    assign word_calc = mask_word(
        rescale_channel(red_reg,   cfg.channel_layout[GROUP_W-1:0]) |
        rescale_channel(green_reg, cfg.channel_layout[2*GROUP_W-1:GROUP_W]) |
        rescale_channel(blue_reg,  cfg.channel_layout[3*GROUP_W-1:2*GROUP_W]) |
        rescale_channel(alpha_reg, cfg.channel_layout[4*GROUP_W-1:3*GROUP_W]),
        bpp);

    assign prod_w   = PROD_W'(cfg.canvas_width) * PROD_W'(scale_reg);
    assign prod_h   = PROD_W'(cfg.canvas_height) * PROD_W'(scale_reg);
    assign row_part = ADDRESS_BITS'(basey_reg) * ADDRESS_BITS'(cfg.line_bytes);
    assign col_part = ADDRESS_BITS'(basex_reg) * ADDRESS_BITS'(bpp);
    assign col_inc  = {1'b0, canvas_col_reg} + (COORD_BITS + 1)'(1);
    assign row_inc  = {1'b0, canvas_row_reg} + (COORD_BITS + 1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        canvas_col_next = canvas_col_reg;
        canvas_row_next = canvas_row_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        alpha_next      = alpha_reg;
        col_snap_next   = col_snap_reg;
        row_snap_next   = row_snap_reg;
        scale_next      = scale_reg;
        word_next       = word_reg;
        offx_next       = offx_reg;
        offy_next       = offy_reg;
        colsc_next      = colsc_reg;
        rowsc_next      = rowsc_reg;
        basex_next      = basex_reg;
        basey_next      = basey_reg;
        in_ready        = 1'b0;
        push            = 1'b0;
        push_data       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scale_next = scale_calc;
                word_next  = word_calc;
                state_next = ST_OFFSET;
            end
            ST_OFFSET:
            begin
                offx_next  = OFF_W'((PROD_W'(cfg.phys_width) - prod_w) >> 1);
                offy_next  = OFF_W'((PROD_W'(cfg.phys_height) - prod_h) >> 1);
                colsc_next = CSC_W'(col_snap_reg) * CSC_W'(scale_reg);
                rowsc_next = CSC_W'(row_snap_reg) * CSC_W'(scale_reg);
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                basex_next = BASE_W'(colsc_reg) + BASE_W'(offx_reg) +
                             BASE_W'(cfg.pan_offsets[PAN_FIELD_W-1:0]);
                basey_next = BASE_W'(rowsc_reg) + BASE_W'(offy_reg) +
                             BASE_W'(cfg.pan_offsets[2*PAN_FIELD_W-1:PAN_FIELD_W]);
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!full)
                begin
                    push     = 1'b1;
                    in_ready = 1'b1;
                    if (scale_reg == '0)
                    begin
                        push_data.too_small = 1'b1;
                        push_data.scale     = scale_reg;
                        push_data.bpp       = bpp;
                    end
                    else
                    begin
                        push_data.start_addr = row_part + col_part;
                        push_data.word       = word_reg;
                        push_data.scale      = scale_reg;
                        push_data.bpp        = bpp;
                        push_data.too_small  = 1'b0;
                    end
                    state_next = in_valid ? ST_SCALE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        accept = in_valid && in_ready;
        if (accept)
        begin
            red_next      = red;
            green_next    = green;
            blue_next     = blue;
            alpha_next    = alpha;
            col_snap_next = canvas_col_reg;
            row_snap_next = canvas_row_reg;
            if (col_inc[COORD_BITS] || (CMP_W'(col_inc) >= CMP_W'(cfg.canvas_width)))
            begin
                canvas_col_next = '0;
                if (row_inc[COORD_BITS] || (CMP_W'(row_inc) >= CMP_W'(cfg.canvas_height)))
                begin
                    canvas_row_next = '0;
                end
                else
                begin
                    canvas_row_next = row_inc[COORD_BITS-1:0];
                end
            end
            else
            begin
                canvas_col_next = col_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            canvas_col_reg <= '0;
            canvas_row_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            canvas_col_reg <= canvas_col_next;
            canvas_row_reg <= canvas_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        alpha_reg    <= alpha_next;
        col_snap_reg <= col_snap_next;
        row_snap_reg <= row_snap_next;
        scale_reg    <= scale_next;
        word_reg     <= word_next;
        offx_reg     <= offx_next;
        offy_reg     <= offy_next;
        colsc_reg    <= colsc_next;
        rowsc_reg    <= rowsc_next;
        basex_reg    <= basex_next;
        basey_reg    <= basey_next;
    end

endmodule

@@ src/iupw_fifo.sv @@
`include "integer_upscale_pixel_writer_unit_assert.svh"

module iupw_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iupw_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output iupw_pkg::work_t head,
    output logic            empty
);
    import iupw_pkg::*;

    work_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IUPW_ASSERT_IMPL(fifo_no_overflow, push, !full)
    `IUPW_ASSERT_IMPL(fifo_no_underflow, pop, !empty)
    `IUPW_ASSERT_NEXT(fifo_fill_shows, push && !pop, !empty)

endmodule

@@ src/iupw_back.sv @@
`include "integer_upscale_pixel_writer_unit_assert.svh"

module iupw_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              empty,
    input  iupw_pkg::work_t                   head,
    output logic                              pop,
    input  logic [iupw_pkg::LINE_W-1:0]       line_bytes,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [iupw_pkg::ADDR_OUT_W-1:0]   byte_address,
    output logic [iupw_pkg::WORD_W-1:0]       pixel_word,
    output logic                              last_of_pixel,
    output logic                              too_small
);
    import iupw_pkg::*;

    logic                    active_reg, active_next;
    work_t                   cur_reg, cur_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [ADDRESS_BITS-1:0] row_start_reg, row_start_next;
    logic [SCALE_W-1:0]      dx_reg, dx_next;
    logic [SCALE_W-1:0]      dy_reg, dy_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_OUT_W-1:0]   byte_address_reg, byte_address_next;
    logic [WORD_W-1:0]       pixel_word_reg, pixel_word_next;
    logic                    last_of_pixel_reg, last_of_pixel_next;
    logic                    too_small_reg, too_small_next;

    logic                    out_free;
    logic                    emit;
    logic                    row_end;
    logic                    last_cur;
    logic                    square_ok;
    logic [ADDRESS_BITS-1:0] new_row;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = active_reg && out_free;
    assign row_end   = (dx_reg == cur_reg.scale - SCALE_W'(1));
    assign last_cur  = cur_reg.too_small ||
                       (row_end && (dy_reg == cur_reg.scale - SCALE_W'(1)));
    assign pop       = !empty && (!active_reg || (emit && last_cur));
    assign new_row   = row_start_reg + ADDRESS_BITS'(line_bytes);
    assign square_ok = (dx_reg < cur_reg.scale) && (dy_reg < cur_reg.scale);

    always_comb
    begin
        active_next        = active_reg;
        cur_next           = cur_reg;
        addr_next          = addr_reg;
        row_start_next     = row_start_reg;
        dx_next            = dx_reg;
        dy_next            = dy_reg;
        out_valid_next     = out_valid_reg;
        byte_address_next  = byte_address_reg;
        pixel_word_next    = pixel_word_reg;
        last_of_pixel_next = last_of_pixel_reg;
        too_small_next     = too_small_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next     = 1'b1;
            byte_address_next  = ADDR_OUT_W'(addr_reg);
            pixel_word_next    = cur_reg.word;
            last_of_pixel_next = last_cur;
            too_small_next     = cur_reg.too_small;
            if (last_cur)
            begin
                active_next = 1'b0;
            end
            else if (row_end)
            begin
                dx_next        = '0;
                dy_next        = dy_reg + SCALE_W'(1);
                row_start_next = new_row;
                addr_next      = new_row;
            end
            else
            begin
                dx_next   = dx_reg + SCALE_W'(1);
                addr_next = addr_reg + ADDRESS_BITS'(cur_reg.bpp);
            end
        end

        if (pop)
        begin
            active_next    = 1'b1;
            cur_next       = head;
            addr_next      = head.start_addr;
            row_start_next = head.start_addr;
            dx_next        = '0;
            dy_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg           <= cur_next;
        addr_reg          <= addr_next;
        row_start_reg     <= row_start_next;
        dx_reg            <= dx_next;
        dy_reg            <= dy_next;
        byte_address_reg  <= byte_address_next;
        pixel_word_reg    <= pixel_word_next;
        last_of_pixel_reg <= last_of_pixel_next;
        too_small_reg     <= too_small_next;
    end

    assign out_valid     = out_valid_reg;
    assign byte_address  = byte_address_reg;
    assign pixel_word    = pixel_word_reg;
    assign last_of_pixel = last_of_pixel_reg;
    assign too_small     = too_small_reg;

    `IUPW_ASSERT_IMPL(back_square_range, active_reg && !cur_reg.too_small, square_ok)
    `IUPW_ASSERT_IMPL(back_error_is_last, out_valid_reg && too_small_reg, last_of_pixel_reg)

endmodule

@@ src/integer_upscale_pixel_writer_unit.sv @@
// Canvas pixels enter one transaction at a time in raster order and each one leaves as
// scale*scale framebuffer write transactions (byte address, packed pixel word, last flag),
// or as a single too_small transaction when the framebuffer cannot hold the canvas. For each
// canvas pixel the front sequencer steps through scale search and channel packing, centering
// offsets, base coordinates and the address multiply, and the back end issues one write per
// cycle while out_ready allows, from a two-entry queue. The registers must be written over
// the APB port only while no pixel is in flight; the block itself does not enforce this.
module integer_upscale_pixel_writer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [iupw_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [iupw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iupw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [iupw_pkg::CHAN_W-1:0]        red,
    input  logic [iupw_pkg::CHAN_W-1:0]        green,
    input  logic [iupw_pkg::CHAN_W-1:0]        blue,
    input  logic [iupw_pkg::CHAN_W-1:0]        alpha,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [iupw_pkg::ADDR_OUT_W-1:0]    byte_address,
    output logic [iupw_pkg::WORD_W-1:0]        pixel_word,
    output logic                               last_of_pixel,
    output logic                               too_small
);
    import iupw_pkg::*;

    cfg_t  cfg;
    work_t push_data;
    work_t head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    iupw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iupw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .cfg       (cfg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    iupw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    iupw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head          (head),
        .pop           (pop),
        .line_bytes    (cfg.line_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_address  (byte_address),
        .pixel_word    (pixel_word),
        .last_of_pixel (last_of_pixel),
        .too_small     (too_small)
    );

endmodule
